### hdl/assert_macros.svh
// assertion macros shared by the step-toward-target modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, ignored while reset is high
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// implication in the next cycle, checked through reset as well
`define ASSERT_NEXT(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

### hdl/vstt_pkg.sv
// constants shared by the step-toward-target pipeline
`timescale 1ns / 1ps
package vstt_pkg;
   localparam int SPEED_W = 16;
   localparam int STEP_W  = 17;
   localparam int SPAN_W  = 26;
   localparam int OUT_W   = 64;
   localparam int FLAG_W  = 1;
endpackage

### hdl/vstt_sqrt_cell.sv
// one root bit of the pipelined integer square root
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vstt_sqrt_cell #(
   parameter int RW = 25,
   parameter int K  = 0,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            up_valid,
   input  logic [2*RW-1:0] up_rem,
   input  logic [RW-1:0]   up_root,
   input  logic [SW-1:0]   up_side,
   output logic            dn_valid,
   output logic [2*RW-1:0] dn_rem,
   output logic [RW-1:0]   dn_root,
   output logic [SW-1:0]   dn_side
);
   import vstt_pkg::*;
   localparam int NW = 2 * RW;

   logic          valid_ff;
   logic [NW-1:0] rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [SW-1:0] side_ff;
   logic [NW-1:0] trial;
   logic          fits;

   // (2*root + 2^k) * 2^k, root has no bits at k or below
   always_comb begin
      trial   = (NW'(up_root) << (K + 1)) | (NW'(1) << (2 * K));
      fits    = up_rem >= trial;
      rem_in  = fits ? up_rem - trial : up_rem;
      root_in = up_root;
      root_in[K] = fits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_side  = side_ff;

   `ASSERT_IMPLIES(a_low_root_clear, clock, reset, valid_ff,
      (root_ff & ((RW'(1) << K) - RW'(1))) == '0)
endmodule

### hdl/vstt_div_cell.sv
// one quotient bit of the two pipelined dividers
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vstt_div_cell #(
   parameter int MW = 25,
   parameter int K  = 0,
   parameter int SW = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          up_valid,
   input  logic [MW+vstt_pkg::SPEED_W-1:0] up_rem_x,
   input  logic [MW+vstt_pkg::SPEED_W-1:0] up_rem_y,
   input  logic [vstt_pkg::SPEED_W-1:0]    up_q_x,
   input  logic [vstt_pkg::SPEED_W-1:0]    up_q_y,
   input  logic [MW-1:0]                 up_div,
   input  logic [SW-1:0]                 up_side,
   output logic                          dn_valid,
   output logic [MW+vstt_pkg::SPEED_W-1:0] dn_rem_x,
   output logic [MW+vstt_pkg::SPEED_W-1:0] dn_rem_y,
   output logic [vstt_pkg::SPEED_W-1:0]    dn_q_x,
   output logic [vstt_pkg::SPEED_W-1:0]    dn_q_y,
   output logic [MW-1:0]                 dn_div,
   output logic [SW-1:0]                 dn_side
);
   import vstt_pkg::*;
   localparam int DVW = MW + SPEED_W;

   logic               valid_ff;
   logic [DVW-1:0]     rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [SPEED_W-1:0] q_x_ff, q_x_in, q_y_ff, q_y_in;
   logic [MW-1:0]      div_ff;
   logic [SW-1:0]      side_ff;
   logic [DVW-1:0]     shifted;
   logic               ge_x, ge_y;

   always_comb begin
      shifted  = DVW'(up_div) << K;
      ge_x     = up_rem_x >= shifted;
      ge_y     = up_rem_y >= shifted;
      rem_x_in = ge_x ? up_rem_x - shifted : up_rem_x;
      rem_y_in = ge_y ? up_rem_y - shifted : up_rem_y;
      q_x_in   = up_q_x;
      q_y_in   = up_q_y;
      q_x_in[K] = ge_x;
      q_y_in[K] = ge_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
         div_ff   <= up_div;
         side_ff  <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem_x = rem_x_ff;
   assign dn_rem_y = rem_y_ff;
   assign dn_q_x   = q_x_ff;
   assign dn_q_y   = q_y_ff;
   assign dn_div   = div_ff;
   assign dn_side  = side_ff;

   // partial remainder stays below the divisor at this weight
   `ASSERT_IMPLIES(a_rem_x_bound, clock, reset, valid_ff && div_ff != '0,
      rem_x_ff < (DVW'(div_ff) << K))
   `ASSERT_IMPLIES(a_rem_y_bound, clock, reset, valid_ff && div_ff != '0,
      rem_y_ff < (DVW'(div_ff) << K))
endmodule

### hdl/vector_step_toward_target_top.sv
// top level: delta, squares, root cell chain, scaling, divider cell chain and result register
//
//   channel | dir | contents
//   req_    | in  | tdata: pos_x, pos_y, target_x, target_y, speed_magnitude
//   rsp_    | out | tdata: step_x, step_y, span; tuser: coincident
//
// one transaction accepted per cycle while the pipeline moves, one result per transaction, in order
// the pipeline holds one cell per root bit,
// sixteen divider cells, and four register stages around them
// the whole pipeline moves only while the result register is empty or taken
// synchronous reset clears the valid bits only
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vector_step_toward_target_top #(
   parameter int COORD_WIDTH = 24
) (
   input  logic clock,
   input  logic reset,
   // pos_x, pos_y, target_x, target_y, speed_magnitude, zero pad
   input  logic [((4*COORD_WIDTH+vstt_pkg::SPEED_W+7)/8)*8-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // step_x, step_y, span, zero pad
   output logic [vstt_pkg::OUT_W-1:0]  rsp_tdata,
   // coincident
   output logic [vstt_pkg::FLAG_W-1:0] rsp_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready
);
   import vstt_pkg::*;
   localparam int CW  = COORD_WIDTH;
   localparam int MW  = CW + 1;
   localparam int NW  = 2 * MW;
   localparam int DVW = MW + SPEED_W;
   localparam int SSW = 2 * MW + 2 + SPEED_W + 1;
   localparam int DSW = 3;
   localparam int PAD = OUT_W - 2 * STEP_W - SPAN_W;

   logic adv;

   // delta stage
   logic [MW-1:0]      dx, dy, magx0_in, magy0_in;
   logic               valid0_ff, negx0_ff, negy0_ff, coinc0_ff;
   logic [MW-1:0]      magx0_ff, magy0_ff;
   logic [SPEED_W-1:0] speed0_ff;

   always_comb begin
      dx = {req_tdata[3*CW-1], req_tdata[3*CW-1:2*CW]}
         - {req_tdata[CW-1], req_tdata[CW-1:0]};
      dy = {req_tdata[4*CW-1], req_tdata[4*CW-1:3*CW]}
         - {req_tdata[2*CW-1], req_tdata[2*CW-1:CW]};
      magx0_in = dx[MW-1] ? ~dx + MW'(1) : dx;
      magy0_in = dy[MW-1] ? ~dy + MW'(1) : dy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (adv) begin
         valid0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         magx0_ff  <= magx0_in;
         magy0_ff  <= magy0_in;
         negx0_ff  <= dx[MW-1];
         negy0_ff  <= dy[MW-1];
         coinc0_ff <= (dx == '0) && (dy == '0);
         speed0_ff <= req_tdata[4*CW+SPEED_W-1:4*CW];
      end
   end

   // squares stage
   logic               valid1_ff, negx1_ff, negy1_ff, coinc1_ff;
   logic [NW-1:0]      sqx1_ff, sqy1_ff;
   logic [MW-1:0]      magx1_ff, magy1_ff;
   logic [SPEED_W-1:0] speed1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (adv) begin
         valid1_ff <= valid0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx1_ff   <= NW'(magx0_ff) * NW'(magx0_ff);
         sqy1_ff   <= NW'(magy0_ff) * NW'(magy0_ff);
         magx1_ff  <= magx0_ff;
         magy1_ff  <= magy0_ff;
         negx1_ff  <= negx0_ff;
         negy1_ff  <= negy0_ff;
         coinc1_ff <= coinc0_ff;
         speed1_ff <= speed0_ff;
      end
   end

   // root cell chain, most significant root bit first
   logic           sq_valid [MW+1];
   logic [NW-1:0]  sq_rem   [MW+1];
   logic [MW-1:0]  sq_root  [MW+1];
   logic [SSW-1:0] sq_side  [MW+1];

   assign sq_valid[0] = valid1_ff;
   assign sq_rem[0]   = sqx1_ff + sqy1_ff;
   assign sq_root[0]  = '0;
   assign sq_side[0]  = {coinc1_ff, speed1_ff, negy1_ff, negx1_ff, magy1_ff, magx1_ff};

   for (genvar i = 0; i < MW; i++) begin : g_sqrt
      vstt_sqrt_cell #(.RW(MW), .K(MW - 1 - i), .SW(SSW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .up_valid (sq_valid[i]),
         .up_rem   (sq_rem[i]),
         .up_root  (sq_root[i]),
         .up_side  (sq_side[i]),
         .dn_valid (sq_valid[i+1]),
         .dn_rem   (sq_rem[i+1]),
         .dn_root  (sq_root[i+1]),
         .dn_side  (sq_side[i+1])
      );
   end

   // scaling stage: magnitude times speed
   logic               validm_ff, negxm_ff, negym_ff, coincm_ff;
   logic [DVW-1:0]     prodx_ff, prody_ff;
   logic [MW-1:0]      spanm_ff;
   logic [MW-1:0]      sq_magx, sq_magy;
   logic [SPEED_W-1:0] sq_speed;

   assign sq_magx  = sq_side[MW][MW-1:0];
   assign sq_magy  = sq_side[MW][2*MW-1:MW];
   assign sq_speed = sq_side[MW][2*MW+2+SPEED_W-1:2*MW+2];

   always_ff @(posedge clock) begin
      if (reset) begin
         validm_ff <= 1'b0;
      end else if (adv) begin
         validm_ff <= sq_valid[MW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prodx_ff  <= DVW'(sq_magx) * DVW'(sq_speed);
         prody_ff  <= DVW'(sq_magy) * DVW'(sq_speed);
         spanm_ff  <= sq_root[MW];
         negxm_ff  <= sq_side[MW][2*MW];
         negym_ff  <= sq_side[MW][2*MW+1];
         coincm_ff <= sq_side[MW][SSW-1];
      end
   end

   // divider cell chain, most significant quotient bit first
   logic               dv_valid [SPEED_W+1];
   logic [DVW-1:0]     dv_rem_x [SPEED_W+1];
   logic [DVW-1:0]     dv_rem_y [SPEED_W+1];
   logic [SPEED_W-1:0] dv_q_x   [SPEED_W+1];
   logic [SPEED_W-1:0] dv_q_y   [SPEED_W+1];
   logic [MW-1:0]      dv_div   [SPEED_W+1];
   logic [DSW-1:0]     dv_side  [SPEED_W+1];

   assign dv_valid[0] = validm_ff;
   assign dv_rem_x[0] = prodx_ff;
   assign dv_rem_y[0] = prody_ff;
   assign dv_q_x[0]   = '0;
   assign dv_q_y[0]   = '0;
   assign dv_div[0]   = spanm_ff;
   assign dv_side[0]  = {coincm_ff, negym_ff, negxm_ff};

   for (genvar i = 0; i < SPEED_W; i++) begin : g_div
      vstt_div_cell #(.MW(MW), .K(SPEED_W - 1 - i), .SW(DSW)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .up_valid (dv_valid[i]),
         .up_rem_x (dv_rem_x[i]),
         .up_rem_y (dv_rem_y[i]),
         .up_q_x   (dv_q_x[i]),
         .up_q_y   (dv_q_y[i]),
         .up_div   (dv_div[i]),
         .up_side  (dv_side[i]),
         .dn_valid (dv_valid[i+1]),
         .dn_rem_x (dv_rem_x[i+1]),
         .dn_rem_y (dv_rem_y[i+1]),
         .dn_q_x   (dv_q_x[i+1]),
         .dn_q_y   (dv_q_y[i+1]),
         .dn_div   (dv_div[i+1]),
         .dn_side  (dv_side[i+1])
      );
   end

   // sign and result register
   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [FLAG_W-1:0]    rsp_user_ff;
   logic [STEP_W-1:0]    qx_ext, qy_ext, step_x, step_y;
   logic                 last_coinc;

   always_comb begin
      last_coinc = dv_side[SPEED_W][2];
      qx_ext = {1'b0, dv_q_x[SPEED_W]};
      qy_ext = {1'b0, dv_q_y[SPEED_W]};
      step_x = dv_side[SPEED_W][0] ? ~qx_ext + STEP_W'(1) : qx_ext;
      step_y = dv_side[SPEED_W][1] ? ~qy_ext + STEP_W'(1) : qy_ext;
      if (last_coinc) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in = {{PAD{1'b0}}, SPAN_W'(dv_div[SPEED_W]), step_y, step_x};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid[SPEED_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= FLAG_W'(last_coinc);
      end
   end

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_IMPLIES(a_coinc_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   `ASSERT_IMPLIES(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready,
      !req_tready)
   `ASSERT_IMPLIES(a_span_nonzero, clock, reset,
      dv_valid[SPEED_W] && !last_coinc, dv_div[SPEED_W] != '0)
   `ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid)
endmodule
